@@ hdl/sspp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_pkg
// Constants and types for the servo status packet parser.
// ----------------------------------------------------------------------------
package sspp_pkg;

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] MIN_LEN      = 8'd4;
	localparam logic [7:0] MAX_LEN      = 8'd20;
	localparam logic [7:0] SERVO_ID_RST = 8'd1;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 16;
	localparam int OUT_W  = POS_W + BYTE_W;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_ID  = 2'd1,
		ST_LEN = 2'd2,
		ST_CHK = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] servo_error;
		logic [POS_W-1:0]  position;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/servo_status_packet_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Parses FF FF ID LEN ERR PARAM... CHK servo replies into status beats.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and can accept a beat every clock cycle,
// except while a stalled result waits and the staged byte completes another.
// A byte passes an input register, then the frame state machine, and any
// result lands in an output register; bytes that give no result keep flowing
// while a result waits there. Each ID mismatch, bad length or checksum error
// gives one error beat (position and servo_error zero); a good frame gives
// status ok, the servo error byte and the position from the first two
// parameters. Asserting restart with a beat drops any partial frame without
// a result. servo_id is written through the cfg channel; the user must do so
// only while the block is idle, as the block does not enforce it.
module servo_status_packet_parser
	import sspp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// config: servo_id
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [BYTE_W-1:0]   cfg_data,
	// input stream
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [BYTE_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	input  wire logic [0:0]          s_axis_tuser,  // [0] restart
	// result stream
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [OUT_W-1:0]         m_axis_tdata,  // [15:0] position, [23:16] servo_error
	output logic [1:0]               m_axis_tuser   // [1:0] status
);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_HDR2  = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_ERR   = 3'd4,
		PH_PARAM = 3'd5,
		PH_CHK   = 3'd6
	} phase_t;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              restart_s1;

	phase_t            phase_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] flen_q;
	logic [BYTE_W-1:0] left_q;
	logic [BYTE_W-1:0] err_q;
	logic [BYTE_W-1:0] plo_q;
	logic [BYTE_W-1:0] phi_q;
	logic [BYTE_W-1:0] id_q;

	logic              out_valid_q;
	result_t           out_q;

	logic              adv;
	logic              go;
	logic              emit;
	result_t           res;
	phase_t            phase_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] left_d;
	logic [BYTE_W-1:0] idx;
	logic [BYTE_W-1:0] sum_add;

	assign adv           = !out_valid_q || m_axis_tready;
	assign go            = valid_s1 && (adv || !emit);
	assign s_axis_tready = !valid_s1 || go;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.servo_error, out_q.position};
	assign m_axis_tuser  = out_q.status;

	assign sum_add = sum_q + byte_s1;
	assign idx     = (flen_q - 8'd2) - left_q;

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		left_d  = left_q;
		emit    = 1'b0;
		res     = '{status: ST_OK, servo_error: '0, position: '0};
		if (restart_s1) begin
			phase_d = PH_HUNT;
			sum_d   = '0;
		end else begin
			unique case (phase_q)
				PH_HDR2: begin
					phase_d = (byte_s1 == HDR_BYTE) ? PH_ID : PH_HUNT;
				end
				PH_ID: begin
					if (byte_s1 != id_q) begin
						phase_d    = PH_HUNT;
						emit       = 1'b1;
						res.status = ST_ID;
					end else begin
						sum_d   = byte_s1;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (byte_s1 < MIN_LEN || byte_s1 > MAX_LEN) begin
						phase_d    = PH_HUNT;
						emit       = 1'b1;
						res.status = ST_LEN;
					end else begin
						left_d  = byte_s1 - 8'd1;
						sum_d   = sum_add;
						phase_d = PH_ERR;
					end
				end
				PH_ERR: begin
					sum_d   = sum_add;
					left_d  = left_q - 8'd1;
					phase_d = PH_PARAM;
				end
				PH_PARAM: begin
					sum_d  = sum_add;
					left_d = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					phase_d = PH_HUNT;
					emit    = 1'b1;
					if (~sum_q != byte_s1) begin
						res.status = ST_CHK;
					end else begin
						res.status      = ST_OK;
						res.position    = {phi_q, plo_q};
						res.servo_error = err_q;
					end
				end
				default: begin
					phase_d = (byte_s1 == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_HUNT;
			sum_q       <= '0;
			flen_q      <= '0;
			left_q      <= '0;
			err_q       <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			id_q        <= SERVO_ID_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				id_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (go) begin
				phase_q <= phase_d;
				sum_q   <= sum_d;
				left_q  <= left_d;
				if (!restart_s1) begin
					if (phase_q == PH_LEN) begin
						flen_q <= byte_s1;
					end
					if (phase_q == PH_ERR) begin
						err_q <= byte_s1;
					end
					if (phase_q == PH_PARAM && idx == 8'd0) begin
						plo_q <= byte_s1;
					end
					if (phase_q == PH_PARAM && idx == 8'd1) begin
						phi_q <= byte_s1;
					end
				end
			end
			if (adv) begin
				out_valid_q <= valid_s1 && emit;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser[0];
		end
		if (valid_s1 && adv && emit) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire
